// ===== src/audio_block_header_parser_top_defines.svh =====
// Assertion macros shared by the block's modules.
`ifndef AUDIO_BLOCK_HEADER_PARSER_TOP_DEFINES_SVH
`define AUDIO_BLOCK_HEADER_PARSER_TOP_DEFINES_SVH

// Same-cycle implication.
`define ABHP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ABHP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/abhp_pkg.sv =====
package abhp_pkg;

  typedef enum logic [3:0] {
    PH_HUNT    = 4'd0,
    PH_FLAGS1  = 4'd1,
    PH_FLAGS2  = 4'd2,
    PH_F1LO    = 4'd3,
    PH_F1HI    = 4'd4,
    PH_F2LO    = 4'd5,
    PH_F2HI    = 4'd6,
    PH_F3LO    = 4'd7,
    PH_F3HI    = 4'd8,
    PH_SKIP1   = 4'd9,
    PH_SKIP2   = 4'd10,
    PH_PAYLOAD = 4'd11
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_SYNC   = 3'd1,
    ST_PARITY = 3'd2,
    ST_FIELD  = 3'd3,
    ST_SIZE   = 3'd4
  } status_t;

  localparam logic [7:0] SYNC_BYTE = 8'h55;
  localparam logic [3:0] COUNT_MAX = 4'd15;

  typedef struct packed {
    status_t     status;
    logic [16:0] block_length;
    logic [3:0]  header_length;
    logic        stereo_flag;
    logic        final_flag;
  } res_t;

endpackage

// ===== src/abhp_parser.sv =====
`include "audio_block_header_parser_top_defines.svh"

module abhp_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  input  logic [7:0]         stream_byte,
  input  logic [15:0]        size_bias,
  output logic               res_valid,
  output abhp_pkg::res_t     res
);

  abhp_pkg::phase_t phase, phase_next;
  logic [15:0] header_flags, header_flags_next;
  logic [7:0]  field_low_byte, field_low_byte_next;
  logic [15:0] first_size_field, first_size_field_next;
  logic [3:0]  header_count, header_count_next;
  logic [16:0] payload_left, payload_left_next;

  logic [3:0]  cnt_inc;
  logic [17:0] size_ext;
  logic [17:0] bias_term;
  logic [17:0] size_sum;
  logic        size_ok;
  logic        parity_odd;
  logic [16:0] payload_dec;

  assign cnt_inc    = (header_count < abhp_pkg::COUNT_MAX) ? header_count + 4'd1 : header_count;
  assign parity_odd = ^stream_byte;
  assign size_ext   = {{2{first_size_field[15]}}, first_size_field};
  assign bias_term  = header_flags[1] ? 18'd0 :
                      (header_flags[3] ? {2'b00, size_bias} : {3'b000, size_bias[15:1]});
  assign size_sum   = size_ext + bias_term;
  assign size_ok    = !size_sum[17] && (size_sum != 18'd0);
  assign payload_dec = (payload_left != 17'd0) ? payload_left - 17'd1 : payload_left;

  // next state
  always_comb begin
    phase_next            = phase;
    header_flags_next     = header_flags;
    field_low_byte_next   = field_low_byte;
    first_size_field_next = first_size_field;
    header_count_next     = header_count;
    payload_left_next     = payload_left;
    if (byte_valid) begin
      if (phase != abhp_pkg::PH_PAYLOAD && phase != abhp_pkg::PH_HUNT) begin
        header_count_next = cnt_inc;
      end
      unique case (phase)
        abhp_pkg::PH_PAYLOAD: begin
          payload_left_next = payload_dec;
          if (payload_dec == 17'd0) phase_next = abhp_pkg::PH_HUNT;
        end
        abhp_pkg::PH_FLAGS1: begin
          if (!parity_odd) begin
            phase_next = abhp_pkg::PH_HUNT;
          end else begin
            header_flags_next = {8'h00, stream_byte};
            phase_next = stream_byte[7] ? abhp_pkg::PH_FLAGS2 : abhp_pkg::PH_F1LO;
          end
        end
        abhp_pkg::PH_FLAGS2: begin
          header_flags_next = {stream_byte, header_flags[7:0]};
          phase_next = abhp_pkg::PH_F1LO;
        end
        abhp_pkg::PH_F1LO: begin
          if (header_flags[14]) begin
            field_low_byte_next = stream_byte;
            phase_next = abhp_pkg::PH_F1HI;
          end else begin
            first_size_field_next = {8'h00, stream_byte};
            phase_next = abhp_pkg::PH_F2LO;
          end
        end
        abhp_pkg::PH_F1HI: begin
          if (stream_byte == 8'h00) begin
            phase_next = abhp_pkg::PH_HUNT;
          end else begin
            first_size_field_next = {stream_byte, field_low_byte};
            phase_next = abhp_pkg::PH_F2LO;
          end
        end
        abhp_pkg::PH_F2LO: begin
          if (header_flags[12]) begin
            field_low_byte_next = stream_byte;
            phase_next = abhp_pkg::PH_F2HI;
          end else begin
            phase_next = abhp_pkg::PH_F3LO;
          end
        end
        abhp_pkg::PH_F2HI: begin
          phase_next = (stream_byte == 8'h00) ? abhp_pkg::PH_HUNT : abhp_pkg::PH_F3LO;
        end
        abhp_pkg::PH_F3LO, abhp_pkg::PH_F3HI: begin
          if (phase == abhp_pkg::PH_F3LO && header_flags[13]) begin
            field_low_byte_next = stream_byte;
            phase_next = abhp_pkg::PH_F3HI;
          end else if (phase == abhp_pkg::PH_F3HI && stream_byte == 8'h00) begin
            phase_next = abhp_pkg::PH_HUNT;
          end else if (header_flags[15]) begin
            phase_next = abhp_pkg::PH_SKIP1;
          end else if (size_ok) begin
            payload_left_next = size_sum[16:0];
            phase_next = abhp_pkg::PH_PAYLOAD;
          end else begin
            phase_next = abhp_pkg::PH_HUNT;
          end
        end
        abhp_pkg::PH_SKIP1: begin
          phase_next = abhp_pkg::PH_SKIP2;
        end
        abhp_pkg::PH_SKIP2: begin
          if (size_ok) begin
            payload_left_next = size_sum[16:0];
            phase_next = abhp_pkg::PH_PAYLOAD;
          end else begin
            phase_next = abhp_pkg::PH_HUNT;
          end
        end
        default: begin
          // hunting, and any stray code
          header_flags_next     = 16'h0000;
          first_size_field_next = 16'h0000;
          field_low_byte_next   = 8'h00;
          header_count_next     = 4'd1;
          phase_next = (stream_byte == abhp_pkg::SYNC_BYTE) ? abhp_pkg::PH_FLAGS1 :
                                                              abhp_pkg::PH_HUNT;
        end
      endcase
    end
  end

  // result
  always_comb begin
    res_valid         = 1'b0;
    res               = '0;
    res.status        = abhp_pkg::ST_OK;
    res.header_length = cnt_inc;
    if (byte_valid) begin
      unique case (phase)
        abhp_pkg::PH_PAYLOAD, abhp_pkg::PH_FLAGS2, abhp_pkg::PH_F2LO,
        abhp_pkg::PH_F1LO, abhp_pkg::PH_SKIP1: begin
          res_valid = 1'b0;
        end
        abhp_pkg::PH_FLAGS1: begin
          res_valid  = !parity_odd;
          res.status = abhp_pkg::ST_PARITY;
        end
        abhp_pkg::PH_F1HI, abhp_pkg::PH_F2HI: begin
          res_valid  = (stream_byte == 8'h00);
          res.status = abhp_pkg::ST_FIELD;
        end
        abhp_pkg::PH_F3LO, abhp_pkg::PH_F3HI, abhp_pkg::PH_SKIP2: begin
          if (phase == abhp_pkg::PH_F3LO && header_flags[13]) begin
            res_valid = 1'b0;
          end else if (phase == abhp_pkg::PH_F3HI && stream_byte == 8'h00) begin
            res_valid  = 1'b1;
            res.status = abhp_pkg::ST_FIELD;
          end else if (phase != abhp_pkg::PH_SKIP2 && header_flags[15]) begin
            res_valid = 1'b0;
          end else if (size_ok) begin
            res_valid        = 1'b1;
            res.block_length = size_sum[16:0];
            res.stereo_flag  = header_flags[3];
            res.final_flag   = header_flags[15];
          end else begin
            res_valid  = 1'b1;
            res.status = abhp_pkg::ST_SIZE;
          end
        end
        default: begin
          res_valid         = (stream_byte != abhp_pkg::SYNC_BYTE);
          res.status        = abhp_pkg::ST_SYNC;
          res.header_length = 4'd1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= abhp_pkg::PH_HUNT;
      header_flags     <= 16'h0000;
      field_low_byte   <= 8'h00;
      first_size_field <= 16'h0000;
      header_count     <= 4'd0;
      payload_left     <= 17'd0;
    end else begin
      phase            <= phase_next;
      header_flags     <= header_flags_next;
      field_low_byte   <= field_low_byte_next;
      first_size_field <= first_size_field_next;
      header_count     <= header_count_next;
      payload_left     <= payload_left_next;
    end
  end

  `ABHP_ASSERT_NEXT(a_ok_enters_payload, res_valid && res.status == abhp_pkg::ST_OK, phase == abhp_pkg::PH_PAYLOAD, "good header did not enter payload")
  `ABHP_ASSERT_NEXT(a_err_hunts, res_valid && res.status != abhp_pkg::ST_OK, phase == abhp_pkg::PH_HUNT, "error did not return to hunting")
  `ABHP_ASSERT_NOW(a_payload_nonzero, phase == abhp_pkg::PH_PAYLOAD, payload_left != 17'd0, "payload phase with nothing left")

endmodule

// ===== src/abhp_out_buf.sv =====
`include "audio_block_header_parser_top_defines.svh"

module abhp_out_buf (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  abhp_pkg::res_t push_res,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output abhp_pkg::res_t out_res
);

  logic           main_valid;
  logic           skid_valid;
  abhp_pkg::res_t main_res;
  abhp_pkg::res_t skid_res;
  logic           pop;

  assign pop       = main_valid && out_ready;
  assign in_ready  = !skid_valid;
  assign out_valid = main_valid;
  assign out_res   = main_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid || pop) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) main_res <= skid_res;
    end else if (push) begin
      if (!main_valid || pop) begin
        main_res <= push_res;
      end else begin
        skid_res <= push_res;
      end
    end
  end

  `ABHP_ASSERT_NOW(a_skid_behind_main, skid_valid, main_valid, "skid stage filled ahead of output")
  `ABHP_ASSERT_NOW(a_no_push_when_full, skid_valid, !push, "result pushed into full buffer")

endmodule

// ===== src/audio_block_header_parser_top.sv =====
// A result is registered in the output buffer before it appears on m_tvalid.
// Throughput: one stream byte per cycle while s_tready is high; each byte is one parser step.
// A two-entry output buffer lets input continue while a result waits; it stalls when both fill.
// Reset (rst, synchronous): parser hunts for sync, buffer empties, size_bias clears to 0.
// Configuration is always ready.
module audio_block_header_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,    // size_bias
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,     // stream_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,     // block_length, header_length, stereo_flag, final_flag, pad
  output logic [2:0]  m_tuser      // status
);

  logic           size_bias_wr;
  logic [15:0]    size_bias;
  logic           byte_valid;
  logic           res_valid;
  abhp_pkg::res_t res;
  abhp_pkg::res_t out_res;

  assign cfg_ready    = 1'b1;
  assign size_bias_wr = cfg_valid && cfg_ready;
  assign byte_valid   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_bias <= 16'h0000;
    end else if (size_bias_wr) begin
      size_bias <= cfg_data;
    end
  end

  abhp_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .stream_byte (s_tdata),
    .size_bias   (size_bias),
    .res_valid   (res_valid),
    .res         (res)
  );

  abhp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_res  (res),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tuser = out_res.status;
  assign m_tdata = {1'b0, out_res.final_flag, out_res.stereo_flag,
                    out_res.header_length, out_res.block_length};

endmodule
